### rtl/core/assert_macros.svh
// assertion macros used by the interpolator unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_CLK_RST(name, clock, reset, prop) \
  name: assert property (@(posedge clock) disable iff (reset) prop) \
    else $error("assertion failed");

`define ASSERT_CLK(name, clock, prop) \
  name: assert property (@(posedge clock) prop) \
    else $error("assertion failed");

`else

`define ASSERT_CLK_RST(name, clock, reset, prop)

`define ASSERT_CLK(name, clock, prop)

`endif

`endif

### rtl/core/mwfi_pkg.sv
`default_nettype none

package mwfi_pkg;

  localparam int MAX_COLS    = 64;
  localparam int MAX_ROWS    = 64;
  localparam int COORD_BITS  = 13;
  localparam int STORE_DEPTH = (MAX_COLS + 1) * (MAX_ROWS + 1);
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  localparam int VIDX_W    = 13;
  localparam int POS_W     = 24;
  localparam int SIZE_W    = 21;
  localparam int GRID_W    = 7;
  localparam int CFG_W     = 21;
  localparam int CFG_IDX_W = 2;

  // pull-in of the last column and row, 1.1 pixels in q.8
  localparam int PULL_IN    = 282;
  localparam int FRAC_SH    = 16;
  localparam int FRAC_LIMIT = 1 << 20;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_PIXEL = 1'b1
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CELL_WIDTH  = 2'd0,
    REG_CELL_HEIGHT = 2'd1,
    REG_GRID_COLS   = 2'd2,
    REG_GRID_ROWS   = 2'd3
  } cfg_reg_t;

endpackage

`default_nettype wire

### rtl/core/mwfi_in_if.sv
`default_nettype none

interface mwfi_in_if;
  import mwfi_pkg::*;

  logic                         valid;
  logic                         ready;
  logic                         opcode;
  logic        [VIDX_W-1:0]     vertex_index;
  logic signed [POS_W-1:0]      vertex_x;
  logic signed [POS_W-1:0]      vertex_y;
  logic        [COORD_BITS-1:0] pixel_x;
  logic        [COORD_BITS-1:0] pixel_y;

  modport source (
    output valid, opcode, vertex_index, vertex_x, vertex_y, pixel_x, pixel_y,
    input  ready
  );

  modport sink (
    input  valid, opcode, vertex_index, vertex_x, vertex_y, pixel_x, pixel_y,
    output ready
  );
endinterface

`default_nettype wire

### rtl/core/mwfi_out_if.sv
`default_nettype none

interface mwfi_out_if;
  import mwfi_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] flow_x;
  logic signed [POS_W-1:0] flow_y;

  modport source (
    output valid, flow_x, flow_y,
    input  ready
  );

  modport sink (
    input  valid, flow_x, flow_y,
    output ready
  );
endinterface

`default_nettype wire

### rtl/core/mesh_warp_flow_interpolator_unit.sv
// channel   dir  transaction
// items     in   one vertex load or one pixel query, valid/ready
// results   out  one flow_x/flow_y pair per pixel query, valid/ready
// cfg       in   cfg_write/cfg_index/cfg_data, taken on every enabled edge
//
// one item enters per cycle while items.ready is high; a pixel result leaves
// the pipeline after the 7-step cell divider and the 22-step fraction
// divider. loads give no result and write the vertex store from the
// memory stage, in order with the pixel reads.
// rst clears the valid bits and config registers, not the vertex store.
// a waiting result with results.ready low freezes every stage; items.ready drops with it.
`default_nettype none
`include "assert_macros.svh"

module mesh_warp_flow_interpolator_unit (
  input  wire                              clk,
  input  wire                              rst,
  mwfi_in_if.sink                          items,
  mwfi_out_if.source                       results,
  input  wire                              cfg_write,
  input  wire  [mwfi_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [mwfi_pkg::CFG_W-1:0]       cfg_data
);
  import mwfi_pkg::*;

  localparam int CN_W  = COORD_BITS + 8;
  localparam int CR_W  = SIZE_W + 1;
  localparam int LO_W  = GRID_W + SIZE_W;
  localparam int FD_W  = CN_W;
  localparam int SPAN_W = SIZE_W + 2;
  localparam int UD_W  = SIZE_W + 1;
  localparam int DV_W  = UD_W + 1;
  localparam int FR_W  = DV_W + 1;
  localparam int FQ_W  = 22;
  localparam int FN_W  = FD_W + FRAC_SH + 2;
  localparam int T_W   = 22;
  localparam int MEM_W = 2 * POS_W;
  localparam int E1_W  = POS_W + 1;
  localparam int M1_W  = E1_W + T_W;
  localparam int R1_W  = M1_W - FRAC_SH;
  localparam int TOP_W = R1_W + 1;
  localparam int E2_W  = TOP_W + 1;
  localparam int M2_W  = E2_W + T_W;
  localparam int R2_W  = M2_W - FRAC_SH;
  localparam int P_W   = R2_W + 1;
  localparam int FL_W  = P_W + 1;

  localparam int S_IN   = 0;
  localparam int S_CDIV = S_IN + 1;
  localparam int S_CELL = S_CDIV + GRID_W;
  localparam int S_ADR  = S_CELL + 1;
  localparam int S_MEM  = S_ADR + 1;
  localparam int S_FDIV = S_MEM + 1;
  localparam int S_TSEL = S_FDIV + FQ_W;
  localparam int S_T    = S_TSEL + 1;
  localparam int S_M1   = S_T + 1;
  localparam int S_R1   = S_M1 + 1;
  localparam int S_A1   = S_R1 + 1;
  localparam int S_E2   = S_A1 + 1;
  localparam int S_M2   = S_E2 + 1;
  localparam int S_R2   = S_M2 + 1;
  localparam int S_P    = S_R2 + 1;
  localparam int S_OUT  = S_P + 1;

  localparam logic [VIDX_W-1:0]   DEPTH_V = VIDX_W'(STORE_DEPTH);
  localparam logic [FQ_W-1:0]     Q_LIM   = FQ_W'(FRAC_LIMIT);
  localparam logic signed [T_W-1:0] T_LIM = T_W'(FRAC_LIMIT);

  typedef struct packed {
    logic                         pix;
    logic        [VIDX_W-1:0]     vidx;
    logic        [POS_W-1:0]      vx;
    logic        [POS_W-1:0]      vy;
    logic        [COORD_BITS-1:0] px;
    logic        [COORD_BITS-1:0] py;
    logic        [CR_W-1:0]       crx;
    logic        [CR_W-1:0]       cry;
    logic        [GRID_W-1:0]     cnx;
    logic        [GRID_W-1:0]     cny;
    logic        [GRID_W-1:0]     cqx;
    logic        [GRID_W-1:0]     cqy;
    logic                         covx;
    logic                         covy;
    logic        [GRID_W-1:0]     cx;
    logic        [GRID_W-1:0]     cy;
    logic        [ADDR_W-1:0]     a0;
    logic        [ADDR_W-1:0]     a3;
    logic        [FD_W-1:0]       dx;
    logic        [FD_W-1:0]       dy;
    logic        [UD_W-1:0]       udx;
    logic        [UD_W-1:0]       udy;
    logic        [DV_W-1:0]       fdx;
    logic        [DV_W-1:0]       fdy;
    logic        [FR_W-1:0]       frx;
    logic        [FR_W-1:0]       fry;
    logic        [FQ_W-1:0]       fnx;
    logic        [FQ_W-1:0]       fny;
    logic        [FQ_W-1:0]       fqx;
    logic        [FQ_W-1:0]       fqy;
    logic                         fovx;
    logic                         fovy;
    logic                         fnegx;
    logic                         fnegy;
    logic                         fzx;
    logic                         fzy;
    logic signed [T_W-1:0]        tx;
    logic signed [T_W-1:0]        ty;
    logic signed [POS_W-1:0]      v0x;
    logic signed [POS_W-1:0]      v0y;
    logic signed [POS_W-1:0]      v3x;
    logic signed [POS_W-1:0]      v3y;
    logic signed [E1_W-1:0]       e0x;
    logic signed [E1_W-1:0]       e0y;
    logic signed [E1_W-1:0]       e3x;
    logic signed [E1_W-1:0]       e3y;
    logic signed [M1_W-1:0]       m0x;
    logic signed [M1_W-1:0]       m0y;
    logic signed [M1_W-1:0]       m3x;
    logic signed [M1_W-1:0]       m3y;
    logic signed [R1_W-1:0]       r0x;
    logic signed [R1_W-1:0]       r0y;
    logic signed [R1_W-1:0]       r3x;
    logic signed [R1_W-1:0]       r3y;
    logic signed [TOP_W-1:0]      topx;
    logic signed [TOP_W-1:0]      topy;
    logic signed [TOP_W-1:0]      botx;
    logic signed [TOP_W-1:0]      boty;
    logic signed [E2_W-1:0]       e2x;
    logic signed [E2_W-1:0]       e2y;
    logic signed [M2_W-1:0]       m2x;
    logic signed [M2_W-1:0]       m2y;
    logic signed [R2_W-1:0]       r2x;
    logic signed [R2_W-1:0]       r2y;
    logic signed [P_W-1:0]        wx;
    logic signed [P_W-1:0]        wy;
    logic signed [POS_W-1:0]      fx;
    logic signed [POS_W-1:0]      fy;
  } item_t;

  // round q16 to nearest, ties away from zero
  function automatic logic signed [R2_W-1:0] rnd16(input logic signed [M2_W-1:0] v);
    logic signed [M2_W-1:0] s;
    s = v + (v[M2_W-1] ? M2_W'(32767) : M2_W'(32768));
    return s[M2_W-1:FRAC_SH];
  endfunction

  function automatic logic signed [POS_W-1:0] sat24(input logic signed [FL_W-1:0] v);
    logic fits;
    fits = (&v[FL_W-1:POS_W-1]) || !(|v[FL_W-1:POS_W-1]);
    if (fits) begin
      return v[POS_W-1:0];
    end
    return v[FL_W-1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
  endfunction

  logic [SIZE_W-1:0] cell_width, cell_height;
  logic [GRID_W-1:0] grid_cols, grid_rows;
  logic [GRID_W-1:0] cols_c, rows_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_width  <= SIZE_W'(8192);
      cell_height <= SIZE_W'(8192);
      grid_cols   <= GRID_W'(16);
      grid_rows   <= GRID_W'(16);
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CELL_WIDTH:  cell_width  <= cfg_data[SIZE_W-1:0];
        REG_CELL_HEIGHT: cell_height <= cfg_data[SIZE_W-1:0];
        REG_GRID_COLS:   grid_cols   <= cfg_data[GRID_W-1:0];
        REG_GRID_ROWS:   grid_rows   <= cfg_data[GRID_W-1:0];
      endcase
    end
  end

  always_comb begin
    cols_c = (grid_cols == '0) ? GRID_W'(1) :
             (grid_cols > GRID_W'(MAX_COLS)) ? GRID_W'(MAX_COLS) : grid_cols;
    rows_c = (grid_rows == '0) ? GRID_W'(1) :
             (grid_rows > GRID_W'(MAX_ROWS)) ? GRID_W'(MAX_ROWS) : grid_rows;
  end

  item_t             pipe [S_OUT+1];
  item_t             nxt  [S_OUT+1];
  logic [S_OUT:0]    pipe_v;
  logic [S_OUT:0]    nxt_v;
  logic              adv;
  logic              load_at_mem;
  logic              frac_ok;

  logic [MEM_W-1:0]  mem_top [STORE_DEPTH];
  logic [MEM_W-1:0]  mem_bot [STORE_DEPTH];
  logic [MEM_W-1:0]  rd0, rd1, rd2, rd3;
  logic [ADDR_W-1:0] adr1, adr2;
  logic              mem_wr;

  assign adv         = !pipe_v[S_OUT] || results.ready;
  assign items.ready = adv;

  assign results.valid  = pipe_v[S_OUT];
  assign results.flow_x = pipe[S_OUT].fx;
  assign results.flow_y = pipe[S_OUT].fy;

  assign adr1   = pipe[S_MEM].a0 + ADDR_W'(1);
  assign adr2   = pipe[S_MEM].a3 + ADDR_W'(1);
  assign mem_wr = pipe_v[S_MEM] && !pipe[S_MEM].pix && (pipe[S_MEM].vidx < DEPTH_V);

  // two copies so the four corners read in the same cycle
  always_ff @(posedge clk) begin
    if (adv) begin
      if (mem_wr) begin
        mem_top[pipe[S_MEM].vidx[ADDR_W-1:0]] <= {pipe[S_MEM].vx, pipe[S_MEM].vy};
        mem_bot[pipe[S_MEM].vidx[ADDR_W-1:0]] <= {pipe[S_MEM].vx, pipe[S_MEM].vy};
      end
      rd0 <= mem_top[pipe[S_MEM].a0];
      rd1 <= mem_top[adr1];
      rd3 <= mem_bot[pipe[S_MEM].a3];
      rd2 <= mem_bot[adr2];
    end
  end

  always_comb begin
    logic [CN_W-1:0]          cn;
    logic [CR_W-1:0]          cr;
    logic [FR_W-1:0]          fr;
    logic [LO_W-1:0]          lo;
    logic [FN_W-1:0]          fnum;
    logic [FQ_W-1:0]          qs;
    logic [ADDR_W-1:0]        stride;
    logic signed [SPAN_W-1:0] span;
    logic                     last;

    for (int i = 1; i <= S_OUT; i++) begin
      nxt[i]   = pipe[i-1];
      nxt_v[i] = pipe_v[i-1];
    end

    // input capture
    nxt[S_IN]              = '0;
    nxt_v[S_IN]            = items.valid;
    nxt[S_IN].pix          = (items.opcode == OP_PIXEL);
    nxt[S_IN].vidx         = items.vertex_index;
    nxt[S_IN].vx           = items.vertex_x;
    nxt[S_IN].vy           = items.vertex_y;
    nxt[S_IN].px           = items.pixel_x;
    nxt[S_IN].py           = items.pixel_y;

    // cell divider setup: numerator is pixel << 8
    cn = {pipe[S_IN].px, 8'h00};
    nxt[S_CDIV].crx  = CR_W'(cn >> GRID_W);
    nxt[S_CDIV].cnx  = cn[GRID_W-1:0];
    nxt[S_CDIV].covx = CR_W'(cn >> GRID_W) >= CR_W'(cell_width);
    nxt[S_CDIV].cqx  = '0;
    cn = {pipe[S_IN].py, 8'h00};
    nxt[S_CDIV].cry  = CR_W'(cn >> GRID_W);
    nxt[S_CDIV].cny  = cn[GRID_W-1:0];
    nxt[S_CDIV].covy = CR_W'(cn >> GRID_W) >= CR_W'(cell_height);
    nxt[S_CDIV].cqy  = '0;

    // cell divider, one quotient bit per stage
    for (int k = 0; k < GRID_W; k++) begin
      cr = {pipe[S_CDIV+k].crx[CR_W-2:0], pipe[S_CDIV+k].cnx[GRID_W-1]};
      nxt[S_CDIV+k+1].cnx = pipe[S_CDIV+k].cnx << 1;
      if (cr >= CR_W'(cell_width)) begin
        nxt[S_CDIV+k+1].crx = cr - CR_W'(cell_width);
        nxt[S_CDIV+k+1].cqx = {pipe[S_CDIV+k].cqx[GRID_W-2:0], 1'b1};
      end else begin
        nxt[S_CDIV+k+1].crx = cr;
        nxt[S_CDIV+k+1].cqx = {pipe[S_CDIV+k].cqx[GRID_W-2:0], 1'b0};
      end
      cr = {pipe[S_CDIV+k].cry[CR_W-2:0], pipe[S_CDIV+k].cny[GRID_W-1]};
      nxt[S_CDIV+k+1].cny = pipe[S_CDIV+k].cny << 1;
      if (cr >= CR_W'(cell_height)) begin
        nxt[S_CDIV+k+1].cry = cr - CR_W'(cell_height);
        nxt[S_CDIV+k+1].cqy = {pipe[S_CDIV+k].cqy[GRID_W-2:0], 1'b1};
      end else begin
        nxt[S_CDIV+k+1].cry = cr;
        nxt[S_CDIV+k+1].cqy = {pipe[S_CDIV+k].cqy[GRID_W-2:0], 1'b0};
      end
    end

    // clamp to the last cell
    nxt[S_ADR].cx = (pipe[S_CELL].covx || pipe[S_CELL].cqx >= cols_c) ?
                    cols_c - GRID_W'(1) : pipe[S_CELL].cqx;
    nxt[S_ADR].cy = (pipe[S_CELL].covy || pipe[S_CELL].cqy >= rows_c) ?
                    rows_c - GRID_W'(1) : pipe[S_CELL].cqy;

    // corner addresses, offset in cell, cell span
    stride = ADDR_W'(cols_c) + ADDR_W'(1);
    nxt[S_MEM].a0 = ADDR_W'(pipe[S_ADR].cy) * stride + ADDR_W'(pipe[S_ADR].cx);
    nxt[S_MEM].a3 = (ADDR_W'(pipe[S_ADR].cy) + ADDR_W'(1)) * stride
                    + ADDR_W'(pipe[S_ADR].cx);

    lo = LO_W'(pipe[S_ADR].cx) * LO_W'(cell_width);
    nxt[S_MEM].dx = FD_W'(LO_W'({pipe[S_ADR].px, 8'h00}) - lo);
    last = (pipe[S_ADR].cx == cols_c - GRID_W'(1));
    span = $signed({2'b00, cell_width}) - (last ? SPAN_W'(PULL_IN) : SPAN_W'(0));
    nxt[S_MEM].fnegx = span[SPAN_W-1];
    nxt[S_MEM].fzx   = (span == '0);
    nxt[S_MEM].udx   = span[SPAN_W-1] ? UD_W'(-span) : UD_W'(span);

    lo = LO_W'(pipe[S_ADR].cy) * LO_W'(cell_height);
    nxt[S_MEM].dy = FD_W'(LO_W'({pipe[S_ADR].py, 8'h00}) - lo);
    last = (pipe[S_ADR].cy == rows_c - GRID_W'(1));
    span = $signed({2'b00, cell_height}) - (last ? SPAN_W'(PULL_IN) : SPAN_W'(0));
    nxt[S_MEM].fnegy = span[SPAN_W-1];
    nxt[S_MEM].fzy   = (span == '0);
    nxt[S_MEM].udy   = span[SPAN_W-1] ? UD_W'(-span) : UD_W'(span);

    // fraction divider setup: (2*d*2^16 + ud) / (2*ud), loads leave here
    nxt_v[S_FDIV] = pipe_v[S_MEM] && pipe[S_MEM].pix;
    fnum = FN_W'({pipe[S_MEM].dx, {(FRAC_SH+1){1'b0}}}) + FN_W'(pipe[S_MEM].udx);
    nxt[S_FDIV].fdx  = {pipe[S_MEM].udx, 1'b0};
    nxt[S_FDIV].frx  = FR_W'(fnum[FN_W-1:FQ_W]);
    nxt[S_FDIV].fnx  = fnum[FQ_W-1:0];
    nxt[S_FDIV].fovx = FR_W'(fnum[FN_W-1:FQ_W]) >= FR_W'({pipe[S_MEM].udx, 1'b0});
    nxt[S_FDIV].fqx  = '0;
    fnum = FN_W'({pipe[S_MEM].dy, {(FRAC_SH+1){1'b0}}}) + FN_W'(pipe[S_MEM].udy);
    nxt[S_FDIV].fdy  = {pipe[S_MEM].udy, 1'b0};
    nxt[S_FDIV].fry  = FR_W'(fnum[FN_W-1:FQ_W]);
    nxt[S_FDIV].fny  = fnum[FQ_W-1:0];
    nxt[S_FDIV].fovy = FR_W'(fnum[FN_W-1:FQ_W]) >= FR_W'({pipe[S_MEM].udy, 1'b0});
    nxt[S_FDIV].fqy  = '0;

    // fraction divider, one quotient bit per stage
    for (int k = 0; k < FQ_W; k++) begin
      fr = {pipe[S_FDIV+k].frx[FR_W-2:0], pipe[S_FDIV+k].fnx[FQ_W-1]};
      nxt[S_FDIV+k+1].fnx = pipe[S_FDIV+k].fnx << 1;
      if (fr >= FR_W'(pipe[S_FDIV+k].fdx)) begin
        nxt[S_FDIV+k+1].frx = fr - FR_W'(pipe[S_FDIV+k].fdx);
        nxt[S_FDIV+k+1].fqx = {pipe[S_FDIV+k].fqx[FQ_W-2:0], 1'b1};
      end else begin
        nxt[S_FDIV+k+1].frx = fr;
        nxt[S_FDIV+k+1].fqx = {pipe[S_FDIV+k].fqx[FQ_W-2:0], 1'b0};
      end
      fr = {pipe[S_FDIV+k].fry[FR_W-2:0], pipe[S_FDIV+k].fny[FQ_W-1]};
      nxt[S_FDIV+k+1].fny = pipe[S_FDIV+k].fny << 1;
      if (fr >= FR_W'(pipe[S_FDIV+k].fdy)) begin
        nxt[S_FDIV+k+1].fry = fr - FR_W'(pipe[S_FDIV+k].fdy);
        nxt[S_FDIV+k+1].fqy = {pipe[S_FDIV+k].fqy[FQ_W-2:0], 1'b1};
      end else begin
        nxt[S_FDIV+k+1].fry = fr;
        nxt[S_FDIV+k+1].fqy = {pipe[S_FDIV+k].fqy[FQ_W-2:0], 1'b0};
      end
    end

    // corner data arrives with the first divider stage
    nxt[S_FDIV+1].v0x = $signed(rd0[MEM_W-1:POS_W]);
    nxt[S_FDIV+1].v0y = $signed(rd0[POS_W-1:0]);
    nxt[S_FDIV+1].v3x = $signed(rd3[MEM_W-1:POS_W]);
    nxt[S_FDIV+1].v3y = $signed(rd3[POS_W-1:0]);
    nxt[S_FDIV+1].e0x = E1_W'($signed(rd1[MEM_W-1:POS_W])) - E1_W'($signed(rd0[MEM_W-1:POS_W]));
    nxt[S_FDIV+1].e0y = E1_W'($signed(rd1[POS_W-1:0])) - E1_W'($signed(rd0[POS_W-1:0]));
    nxt[S_FDIV+1].e3x = E1_W'($signed(rd2[MEM_W-1:POS_W])) - E1_W'($signed(rd3[MEM_W-1:POS_W]));
    nxt[S_FDIV+1].e3y = E1_W'($signed(rd2[POS_W-1:0])) - E1_W'($signed(rd3[POS_W-1:0]));

    // saturate and sign the fractions
    qs = (pipe[S_TSEL].fovx || pipe[S_TSEL].fqx > Q_LIM) ? Q_LIM : pipe[S_TSEL].fqx;
    nxt[S_T].tx = pipe[S_TSEL].fzx ? '0 :
                  (pipe[S_TSEL].fnegx ? -$signed(qs) : $signed(qs));
    qs = (pipe[S_TSEL].fovy || pipe[S_TSEL].fqy > Q_LIM) ? Q_LIM : pipe[S_TSEL].fqy;
    nxt[S_T].ty = pipe[S_TSEL].fzy ? '0 :
                  (pipe[S_TSEL].fnegy ? -$signed(qs) : $signed(qs));

    // x pass
    nxt[S_M1].m0x = M1_W'(pipe[S_T].e0x) * M1_W'(pipe[S_T].tx);
    nxt[S_M1].m3x = M1_W'(pipe[S_T].e3x) * M1_W'(pipe[S_T].tx);
    nxt[S_M1].m0y = M1_W'(pipe[S_T].e0y) * M1_W'(pipe[S_T].tx);
    nxt[S_M1].m3y = M1_W'(pipe[S_T].e3y) * M1_W'(pipe[S_T].tx);

    nxt[S_R1].r0x = R1_W'(rnd16(M2_W'(pipe[S_M1].m0x)));
    nxt[S_R1].r3x = R1_W'(rnd16(M2_W'(pipe[S_M1].m3x)));
    nxt[S_R1].r0y = R1_W'(rnd16(M2_W'(pipe[S_M1].m0y)));
    nxt[S_R1].r3y = R1_W'(rnd16(M2_W'(pipe[S_M1].m3y)));

    nxt[S_A1].topx = TOP_W'(pipe[S_R1].v0x) + TOP_W'(pipe[S_R1].r0x);
    nxt[S_A1].botx = TOP_W'(pipe[S_R1].v3x) + TOP_W'(pipe[S_R1].r3x);
    nxt[S_A1].topy = TOP_W'(pipe[S_R1].v0y) + TOP_W'(pipe[S_R1].r0y);
    nxt[S_A1].boty = TOP_W'(pipe[S_R1].v3y) + TOP_W'(pipe[S_R1].r3y);

    // y pass
    nxt[S_E2].e2x = E2_W'(pipe[S_A1].botx) - E2_W'(pipe[S_A1].topx);
    nxt[S_E2].e2y = E2_W'(pipe[S_A1].boty) - E2_W'(pipe[S_A1].topy);

    nxt[S_M2].m2x = M2_W'(pipe[S_E2].e2x) * M2_W'(pipe[S_E2].ty);
    nxt[S_M2].m2y = M2_W'(pipe[S_E2].e2y) * M2_W'(pipe[S_E2].ty);

    nxt[S_R2].r2x = rnd16(pipe[S_M2].m2x);
    nxt[S_R2].r2y = rnd16(pipe[S_M2].m2y);

    nxt[S_P].wx = P_W'(pipe[S_R2].topx) + P_W'(pipe[S_R2].r2x);
    nxt[S_P].wy = P_W'(pipe[S_R2].topy) + P_W'(pipe[S_R2].r2y);

    // flow and saturation
    nxt[S_OUT].fx = sat24(FL_W'(pipe[S_P].wx) - FL_W'($signed({1'b0, pipe[S_P].px, 8'h00})));
    nxt[S_OUT].fy = sat24(FL_W'(pipe[S_P].wy) - FL_W'($signed({1'b0, pipe[S_P].py, 8'h00})));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_v <= '0;
    end else if (adv) begin
      pipe_v <= nxt_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i <= S_OUT; i++) begin
        pipe[i] <= nxt[i];
      end
    end
  end

  assign load_at_mem = pipe_v[S_MEM] && !pipe[S_MEM].pix;
  assign frac_ok     = pipe[S_T].tx <= T_LIM && pipe[S_T].tx >= -T_LIM &&
                       pipe[S_T].ty <= T_LIM && pipe[S_T].ty >= -T_LIM;

  `ASSERT_CLK(a_reset_clears_pipe, clk, rst |=> pipe_v == '0)
  `ASSERT_CLK_RST(a_load_leaves_after_write, clk, rst, load_at_mem && adv |=> !pipe_v[S_FDIV])
  `ASSERT_CLK_RST(a_stall_freezes_pipe, clk, rst, !adv |=> $stable(pipe_v))
  `ASSERT_CLK_RST(a_frac_in_range, clk, rst, pipe_v[S_T] |-> frac_ok)

endmodule

`default_nettype wire

### dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import mwfi_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 60;
  localparam int BASE_STRIDE = 17;
  localparam longint FRAC_ONE = 65536;
  localparam longint POS_MAX = 8388607;
  localparam longint POS_MIN = -8388608;

  class flow_scoreboard;
    longint warp_x[STORE_DEPTH];
    longint warp_y[STORE_DEPTH];
    int unsigned cell_w, cell_h, cols_reg, rows_reg;
    longint flow_x_q[$];
    longint flow_y_q[$];
    int errors;

    function new();
      cell_w = 8192;
      cell_h = 8192;
      cols_reg = 16;
      rows_reg = 16;
      errors = 0;
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    function void set_reg(cfg_reg_t idx, int unsigned val);
      case (idx)
        REG_CELL_WIDTH: cell_w = val & 21'h1fffff;
        REG_CELL_HEIGHT: cell_h = val & 21'h1fffff;
        REG_GRID_COLS: cols_reg = val & 7'h7f;
        REG_GRID_ROWS: rows_reg = val & 7'h7f;
      endcase
    endfunction

    function void expect_flow(longint fx, longint fy);
      flow_x_q = {flow_x_q, fx};
      flow_y_q = {flow_y_q, fy};
    endfunction

    function longint round_div(longint num, longint den);
      bit neg;
      longint un, ud, q;
      neg = (num < 0) != (den < 0);
      un = num < 0 ? -num : num;
      ud = den < 0 ? -den : den;
      q = (2 * un + ud) / (2 * ud);
      return neg ? -q : q;
    endfunction

    function int unsigned clamp_count(int unsigned n, int unsigned maxn);
      if (n < 1) return 1;
      return n > maxn ? maxn : n;
    endfunction

    function int unsigned cell_index(int unsigned pix, int unsigned size, int unsigned cnt);
      longint q;
      if (size == 0) return cnt - 1;
      q = (longint'(pix) * 256) / size;
      return q >= cnt ? cnt - 1 : int'(q);
    endfunction

    function longint cell_frac(int unsigned pix, int unsigned c, int unsigned size,
                               int unsigned cnt);
      longint lo, hi, t;
      lo = longint'(c) * size;
      hi = longint'(c + 1) * size;
      if (c + 1 == cnt) hi -= PULL_IN;
      if (hi == lo) return 0;
      t = round_div((longint'(pix) * 256 - lo) * FRAC_ONE, hi - lo);
      if (t > FRAC_LIMIT) t = FRAC_LIMIT;
      if (t < -FRAC_LIMIT) t = -FRAC_LIMIT;
      return t;
    endfunction

    function longint blend(longint a, longint b, longint t);
      return a + round_div((b - a) * t, FRAC_ONE);
    endfunction

    function longint saturate(longint v);
      if (v > POS_MAX) return POS_MAX;
      if (v < POS_MIN) return POS_MIN;
      return v;
    endfunction

    function void note_item(opcode_t op, int unsigned vidx, longint vx, longint vy,
                            int unsigned px, int unsigned py);
      int unsigned cols, rows, cx, cy, i0, i1, i2, i3;
      longint tx, ty, top, bot, wx, wy;
      if (op == OP_LOAD) begin
        if (vidx < STORE_DEPTH) begin
          warp_x[vidx] = vx;
          warp_y[vidx] = vy;
        end
        return;
      end
      cols = clamp_count(cols_reg, MAX_COLS);
      rows = clamp_count(rows_reg, MAX_ROWS);
      cx = cell_index(px, cell_w, cols);
      cy = cell_index(py, cell_h, rows);
      i0 = cy * (cols + 1) + cx;
      i1 = i0 + 1;
      i3 = i0 + cols + 1;
      i2 = i3 + 1;
      tx = cell_frac(px, cx, cell_w, cols);
      ty = cell_frac(py, cy, cell_h, rows);
      top = blend(warp_x[i0], warp_x[i1], tx);
      bot = blend(warp_x[i3], warp_x[i2], tx);
      wx = blend(top, bot, ty);
      top = blend(warp_y[i0], warp_y[i1], tx);
      bot = blend(warp_y[i3], warp_y[i2], tx);
      wy = blend(top, bot, ty);
      expect_flow(saturate(wx - longint'(px) * 256), saturate(wy - longint'(py) * 256));
    endfunction

    task check_flow(longint fx, longint fy);
      longint ex, ey;
      if (flow_x_q.size() == 0) begin
        report($sformatf("unexpected flow result x=%0d y=%0d", fx, fy));
        return;
      end
      ex = flow_x_q.pop_front();
      ey = flow_y_q.pop_front();
      if (fx != ex) report($sformatf("flow_x got %0d want %0d", fx, ex));
      if (fy != ey) report($sformatf("flow_y got %0d want %0d", fy, ey));
    endtask
  endclass

  logic clk;
  logic rst;
  logic cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  mwfi_in_if items ();
  mwfi_out_if results ();

  mesh_warp_flow_interpolator_unit uut (
    .clk(clk),
    .rst(rst),
    .items(items.sink),
    .results(results.source),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  flow_scoreboard sb = new();
  bit idle_en = 1;
  bit hold_req = 0;
  int cycles = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // result side back-pressure
  initial begin
    int stall, hold;
    stall = 0;
    hold = 0;
    results.ready <= 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 0;
        hold = 400;
      end
      if (hold > 0) begin
        results.ready <= 0;
        hold--;
      end else if (stall > 0) begin
        results.ready <= 0;
        stall--;
      end else if (idle_en && $urandom_range(0, 11) == 0) begin
        stall = $urandom_range(1, 17) - 1;
        results.ready <= 0;
      end else begin
        results.ready <= 1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (items.valid && items.ready)
        sb.note_item(opcode_t'(items.opcode), items.vertex_index, items.vertex_x,
                     items.vertex_y, items.pixel_x, items.pixel_y);
      if (results.valid && results.ready)
        sb.check_flow(results.flow_x, results.flow_y);
    end
  end

  task send_item(opcode_t op, int unsigned vidx, longint vx, longint vy,
                 int unsigned px, int unsigned py);
    if (idle_en && $urandom_range(0, 9) == 0) begin
      items.valid <= 0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    items.valid <= 1;
    items.opcode <= op;
    items.vertex_index <= vidx[VIDX_W-1:0];
    items.vertex_x <= vx[POS_W-1:0];
    items.vertex_y <= vy[POS_W-1:0];
    items.pixel_x <= px[COORD_BITS-1:0];
    items.pixel_y <= py[COORD_BITS-1:0];
    do @(posedge clk); while (!items.ready);
  endtask

  task load_vertex(int unsigned vidx, longint vx, longint vy);
    send_item(OP_LOAD, vidx, vx, vy, $urandom, $urandom);
  endtask

  task query_pixel(int unsigned px, int unsigned py);
    send_item(OP_PIXEL, $urandom, $urandom, $urandom, px, py);
  endtask

  task drain();
    items.valid <= 0;
    while (sb.flow_x_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task write_grid(int unsigned cw, int unsigned ch, int unsigned cols, int unsigned rows);
    cfg_reg_t idx[4];
    int unsigned val[4];
    idx = '{REG_CELL_WIDTH, REG_CELL_HEIGHT, REG_GRID_COLS, REG_GRID_ROWS};
    val = '{cw, ch, cols, rows};
    for (int i = 0; i < 4; i++) begin
      cfg_write <= 1;
      cfg_index <= idx[i];
      cfg_data <= val[i][CFG_W-1:0];
      sb.set_reg(idx[i], val[i]);
      @(posedge clk);
    end
    cfg_write <= 0;
  endtask

  function automatic longint near_grid(int unsigned n, int unsigned size);
    longint v;
    v = longint'(n) * size + $signed($urandom_range(0, 4000)) - 2000;
    if (v > POS_MAX) v = POS_MAX;
    if (v < POS_MIN) v = POS_MIN;
    return v;
  endfunction

  // first two columns of every row of a full-width grid
  task load_column_pair(int unsigned stride, int unsigned nrows, int unsigned size_y);
    for (int r = 0; r <= nrows; r++) begin
      load_vertex(r * stride, near_grid(0, 8192), near_grid(r, size_y));
      load_vertex(r * stride + 1, near_grid(1, 8192), near_grid(r, size_y));
    end
  endtask

  task random_items(int n);
    int unsigned cols, rows, span_x, span_y, nverts, vidx;
    longint vx, vy;
    cols = sb.clamp_count(sb.cols_reg, MAX_COLS);
    rows = sb.clamp_count(sb.rows_reg, MAX_ROWS);
    span_x = (longint'(cols) * sb.cell_w) / 256 + 8;
    span_y = (longint'(rows) * sb.cell_h) / 256 + 8;
    if (span_x > 8191) span_x = 8191;
    if (span_y > 8191) span_y = 8191;
    nverts = (cols + 1) * (rows + 1);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 3) begin
        vidx = $urandom_range(0, 19) == 0 ? $urandom_range(0, 8191)
                                          : $urandom_range(0, nverts - 1);
        if ($urandom_range(0, 9) < 7) begin
          vx = near_grid(vidx % (cols + 1), sb.cell_w);
          vy = near_grid(vidx / (cols + 1), sb.cell_h);
        end else begin
          vx = $signed(24'($urandom));
          vy = $signed(24'($urandom));
        end
        load_vertex(vidx, vx, vy);
      end else if ($urandom_range(0, 4) == 0) begin
        query_pixel($urandom_range(0, 8191), $urandom_range(0, 8191));
      end else begin
        query_pixel($urandom_range(0, span_x), $urandom_range(0, span_y));
      end
    end
  endtask

  initial begin
    int unsigned cw, ch;
    rst = 1;
    cfg_write <= 0;
    cfg_index <= REG_CELL_WIDTH;
    cfg_data <= '0;
    items.valid <= 0;
    items.opcode <= OP_LOAD;
    items.vertex_index <= '0;
    items.vertex_x <= '0;
    items.vertex_y <= '0;
    items.pixel_x <= '0;
    items.pixel_y <= '0;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // every entry that a grid of up to 16 by 16 cells reads gets a value first
    for (int i = 0; i < BASE_STRIDE * BASE_STRIDE; i++)
      load_vertex(i, near_grid(i % BASE_STRIDE, 8192), near_grid(i / BASE_STRIDE, 8192));

    // directed: extremes, ignored loads, reset grid
    load_vertex(0, POS_MAX, POS_MIN);
    load_vertex(STORE_DEPTH - 1, POS_MIN, POS_MAX);
    load_vertex(STORE_DEPTH, 0, 0);
    load_vertex(8191, POS_MAX, POS_MAX);
    load_vertex(17, POS_MIN, POS_MIN);
    query_pixel(0, 0);
    query_pixel(8191, 8191);
    query_pixel(511, 511);
    query_pixel(510, 509);
    query_pixel(32, 32);
    query_pixel(8191, 0);
    query_pixel(0, 8191);
    random_items(30);
    drain();

    // one-pixel cells, one cell; long result stall while items keep coming
    write_grid(256, 256, 1, 1);
    hold_req = 1;
    query_pixel(0, 0);
    query_pixel(1, 1);
    query_pixel(8191, 8191);
    random_items(60);
    drain();

    // largest cells, every pixel in the first cell
    write_grid(2097151, 2097151, 64, 64);
    query_pixel(8191, 8191);
    query_pixel(0, 8191);
    random_items(25);
    drain();

    // zero size registers clamp, zero cell size
    write_grid(0, 0, 0, 0);
    query_pixel(0, 0);
    query_pixel(8191, 3);
    random_items(20);
    drain();

    // grid above maximum, cell equal to pull-in on last column
    write_grid(PULL_IN, 2097151, 127, 127);
    query_pixel(63, 63);
    query_pixel(64, 64);
    query_pixel(8191, 8191);
    random_items(25);
    drain();

    // grid above maximum, cell equal to pull-in on last row
    write_grid(2097151, PULL_IN, 127, 127);
    load_column_pair(MAX_COLS + 1, MAX_ROWS, PULL_IN);
    query_pixel(63, 63);
    query_pixel(64, 64);
    query_pixel(8191, 8191);
    random_items(25);
    drain();

    for (int p = 0; p < 3; p++) begin
      cw = $urandom_range(256, 40000);
      ch = $urandom_range(256, 40000);
      write_grid(cw, ch, $urandom_range(1, 16), $urandom_range(1, 16));
      random_items(30);
      drain();
    end

    // final stretch without idling
    write_grid(6000, 9000, 12, 10);
    idle_en = 0;
    random_items(40);
    drain();

    if (sb.flow_x_q.size() != 0)
      sb.report("expected flow results left over");
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

### files.f
+incdir+rtl/core
rtl/core/mwfi_pkg.sv
rtl/core/mwfi_in_if.sv
rtl/core/mwfi_out_if.sv
rtl/core/mesh_warp_flow_interpolator_unit.sv
dv/testbench.sv
